@@ rtl/fpl_pkg.sv @@
package fpl_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  // 4*centre minus four neighbours of 32 bits fits in 36 bits, signed
  localparam int SUM_W = DATA_W + 4;
  localparam int GW_W = 11;
  localparam int GH_W = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [DATA_W-1:0] INV_H2_RESET = 32'h0001_0000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1,
    CFG_INV_H2      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic emit;
    logic last;
  } item_flags_t;

endpackage

@@ rtl/fpl_ram.sv @@
module fpl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

@@ rtl/fpl_scale.sv @@
module fpl_scale (
  input  logic                               clk,
  input  logic                               load,
  input  logic signed [fpl_pkg::SUM_W-1:0]   sum_in,
  input  logic        [fpl_pkg::DATA_W-1:0]  inv_h2,
  output logic signed [fpl_pkg::DATA_W-1:0]  result
);
  import fpl_pkg::*;

  localparam int HALF_W = DATA_W / 2;
  localparam int PROD_W = SUM_W + HALF_W + 1;
  localparam int TOT_W = PROD_W + 1;
  localparam logic signed [TOT_W-1:0] RND_HALF = TOT_W'(1) <<< (FRAC_W - 1);

  logic signed [HALF_W:0]   inv_hi;
  logic signed [HALF_W:0]   inv_lo;
  logic signed [PROD_W-1:0] prod_hi;
  logic signed [PROD_W-1:0] prod_lo;
  logic signed [PROD_W-1:0] prod_hi_r;
  logic signed [PROD_W-1:0] prod_lo_r;
  logic signed [TOT_W-1:0]  lo_rnd;
  logic signed [TOT_W-1:0]  total;
  logic                     ovf;

  // split the scale into halves so each multiply stays near 36x17
  assign inv_hi  = $signed({1'b0, inv_h2[DATA_W-1:HALF_W]});
  assign inv_lo  = $signed({1'b0, inv_h2[HALF_W-1:0]});
  assign prod_hi = sum_in * inv_hi;
  assign prod_lo = sum_in * inv_lo;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_hi_r <= prod_hi;
      prod_lo_r <= prod_lo;
    end
  end

  // round half up: floor((lo + 2^15) / 2^16), then add the integer part
  assign lo_rnd = (TOT_W'(prod_lo_r) + RND_HALF) >>> FRAC_W;
  assign total  = TOT_W'(prod_hi_r) + lo_rnd;
  assign ovf    = !((&total[TOT_W-1:DATA_W-1]) || !(|total[TOT_W-1:DATA_W-1]));

  always_comb begin
    if (ovf) begin
      result = total[TOT_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      result = total[DATA_W-1:0];
    end
  end

endmodule

@@ rtl/five_point_laplacian_apply_unit.sv @@
// Five-point negative Laplacian over a raster grid stream. Feed the whole grid, boundary ring
// included, one point per beat in row-major order; in_tdata carries interior_value in bits 31:0
// and boundary_value in bits 63:32, and the unit picks the boundary value on the outer ring.
// For every interior point it returns (4*centre - up - down - left - right) * inv_h_squared,
// signed Q16.16, rounded half up and saturated to 32 bits, in raster order; the result for the
// final interior point carries out_tlast. The result for point (r-1, c-1) becomes available once
// point (r, c) has been taken, so ring points produce no beat. The unit takes one point every
// clock unless the output stalls: the two previous rows sit side by side in one line RAM of
// MAX_WIDTH entries, which sees one read (new column) and one write (column of the point
// before) per cycle. out_tvalid for a result rises once the beat that completes it has passed
// in order through the RAM read, window and sum, split multiply, and round and saturate into
// the output register, each registered. The line RAM needs no clearing pass after reset.
// Write grid_width (index 0) or grid_height (index 1) only while idle; either write restarts the
// frame at row 0, column 0. Width is clamped to [3, MAX_WIDTH], height to at least 3.
module five_point_laplacian_apply_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: interior_value [31:0], boundary_value [63:32]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [2*fpl_pkg::DATA_W-1:0]       in_tdata,
  // out_tdata: stencil_value [31:0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [fpl_pkg::DATA_W-1:0]         out_tdata,
  output logic                               out_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fpl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [fpl_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fpl_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CW_W = (COL_W + 1 > GW_W) ? COL_W + 1 : GW_W;

  // configuration, kept as last column / last row / scale
  logic [COL_W-1:0]  last_col_r;
  logic [GH_W-1:0]   last_row_r;
  logic [DATA_W-1:0] inv_h2_r;
  logic [CW_W-1:0]   gw_ext;
  logic [CW_W-1:0]   gw_clamp;
  logic [GH_W-1:0]   gh_clamp;
  logic              cfg_wr;
  logic              restart;

  // position of the next point
  logic [COL_W-1:0]  col_r;
  logic [GH_W-1:0]   row_r;
  logic              in_beat;
  logic              ring;
  logic              at_last_col;
  logic              at_last_row;

  // pipeline
  logic                     s1_v_r;
  logic [COL_W-1:0]         s1_col_r;
  logic signed [DATA_W-1:0] s1_val_r;
  item_flags_t              s1_flags_r;
  item_flags_t              in_flags;
  logic                     s2_v_r;
  logic signed [SUM_W-1:0]  s2_sum_r;
  logic                     s2_last_r;
  logic                     s3_v_r;
  logic                     s3_last_r;
  logic                     out_valid_r;
  logic [DATA_W-1:0]        out_data_r;
  logic                     out_last_r;
  logic                     go_out;
  logic                     free1;
  logic                     free2;
  logic                     free3;
  logic                     adv1;
  logic                     adv2;

  // line RAM: {row r-2, row r-1} per column
  logic [2*DATA_W-1:0]      ram_rdata;
  logic [2*DATA_W-1:0]      ram_wdata;
  logic signed [DATA_W-1:0] older_rd;
  logic signed [DATA_W-1:0] newer_rd;

  // stencil taps; the corners of the 3x3 window never feed the sum, so only these are held
  logic signed [DATA_W-1:0] up_r;
  logic signed [DATA_W-1:0] down_r;
  logic signed [DATA_W-1:0] mid_r;
  logic signed [DATA_W-1:0] mid_prev_r;
  logic signed [SUM_W-1:0]  sum;
  logic signed [DATA_W-1:0] scaled;

  // ---------------------------------------------------------------- configuration
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign restart   = cfg_wr && (cfg_addr == CFG_GRID_WIDTH || cfg_addr == CFG_GRID_HEIGHT);

  assign gw_ext = CW_W'(cfg_data[GW_W-1:0]);

  always_comb begin
    priority if (gw_ext < CW_W'(3)) begin
      gw_clamp = CW_W'(3);
    end else if (gw_ext > CW_W'(MAX_WIDTH)) begin
      gw_clamp = CW_W'(MAX_WIDTH);
    end else begin
      gw_clamp = gw_ext;
    end
    gh_clamp = (cfg_data[GH_W-1:0] < GH_W'(3)) ? GH_W'(3) : cfg_data[GH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= COL_W'(2);
      last_row_r <= GH_W'(2);
      inv_h2_r   <= INV_H2_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_addr)
        CFG_GRID_WIDTH:  last_col_r <= COL_W'(gw_clamp - CW_W'(1));
        CFG_GRID_HEIGHT: last_row_r <= gh_clamp - GH_W'(1);
        CFG_INV_H2:      inv_h2_r   <= cfg_data[DATA_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------- position and ring
  assign in_tready   = free1;
  assign in_beat     = in_tvalid && in_tready;
  assign at_last_col = (col_r == last_col_r);
  assign at_last_row = (row_r == last_row_r);
  assign ring        = (row_r == '0) || at_last_row || (col_r == '0) || at_last_col;

  always_comb begin
    in_flags.emit = (row_r >= GH_W'(2)) && (col_r >= COL_W'(2));
    in_flags.last = at_last_row && at_last_col;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (restart) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_beat) begin
      if (at_last_col) begin
        col_r <= '0;
        row_r <= at_last_row ? '0 : row_r + GH_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------- stall chain
  assign go_out = !out_valid_r || out_tready;
  assign free3  = !s3_v_r || go_out;
  assign free2  = !s2_v_r || free3;
  assign free1  = !s1_v_r || free2;
  assign adv1   = s1_v_r && free2;
  assign adv2   = s2_v_r && free3;

  // ---------------------------------------------------------------- stage 1: RAM read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (free1) begin
      s1_v_r <= in_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_col_r   <= col_r;
      s1_val_r   <= ring ? in_tdata[2*DATA_W-1:DATA_W] : in_tdata[DATA_W-1:0];
      s1_flags_r <= in_flags;
    end
  end

  fpl_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .we      (adv1),
    .waddr   (s1_col_r),
    .wdata   (ram_wdata),
    .re      (in_beat),
    .raddr   (col_r),
    .rdata_r (ram_rdata)
  );

  assign older_rd  = ram_rdata[2*DATA_W-1:DATA_W];
  assign newer_rd  = ram_rdata[DATA_W-1:0];
  // age the column: row r-1 moves to r-2, the new point becomes row r-1
  assign ram_wdata = {newer_rd, s1_val_r};

  // ---------------------------------------------------------------- stage 2: window and sum
  assign sum = (SUM_W'(mid_r) <<< 2) - SUM_W'(up_r) - SUM_W'(down_r)
             - SUM_W'(mid_prev_r) - SUM_W'(newer_rd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r       <= '0;
      down_r     <= '0;
      mid_r      <= '0;
      mid_prev_r <= '0;
    end else if (adv1) begin
      up_r       <= older_rd;
      down_r     <= s1_val_r;
      mid_r      <= newer_rd;
      mid_prev_r <= mid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (free2) begin
      s2_v_r <= s1_v_r && s1_flags_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_sum_r  <= sum;
      s2_last_r <= s1_flags_r.last;
    end
  end

  // ---------------------------------------------------------------- stage 3: scale
  fpl_scale u_scale (
    .clk    (clk),
    .load   (adv2),
    .sum_in (s2_sum_r),
    .inv_h2 (inv_h2_r),
    .result (scaled)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (free3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s3_last_r <= s2_last_r;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go_out) begin
      out_valid_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go_out && s3_v_r) begin
      out_data_r <= scaled;
      out_last_r <= s3_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------- checks
  // the read of a new column never collides with the write-back of the previous one
  a_ram_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (adv1 && in_beat) |-> (s1_col_r != col_r))
    else $error("line RAM read and write hit the same column");

  // the column counter stays inside the configured width
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= last_col_r)
    else $error("column counter past last column");

  // the final point of the grid returns the position to the origin
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && at_last_col && at_last_row && !restart) |=> (col_r == '0 && row_r == '0))
    else $error("position did not wrap at end of frame");

  // a point held in stage 1 blocks new beats, so RAM read data is never overwritten
  a_hold_rdata: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !free2) |-> !in_tready)
    else $error("input taken while stage 1 is stalled");

endmodule
